// ----- rtl/odo_pkg.sv -----
package odo_pkg;

  // Wheel set and counter wrap
  localparam int WHEEL_COUNT     = 4;
  localparam int COUNTER_MODULUS = 10000;
  localparam int LF = 0;
  localparam int LB = 1;
  localparam int RF = 2;
  localparam int RB = 3;

  // Field widths
  localparam int CNT_W = 14;
  localparam int MAG_W = 13;  // largest unwrapped count magnitude is 6383
  localparam int DPC_W = 24;
  localparam int SPS_W = 16;
  localparam int ITH_W = 24;
  localparam int VEL_W = 32;
  localparam int ACC_W = 48;
  localparam int IDX_W = 2;
  localparam int CFG_W = 24;

  localparam logic [CNT_W-1:0] HALF_C = CNT_W'(COUNTER_MODULUS / 2);
  localparam logic [CNT_W-1:0] MOD_C  = CNT_W'(COUNTER_MODULUS);

  // Lane datapath widths
  localparam int RND_SHIFT = 8;
  localparam int RND_HALF  = 128;
  localparam int PM_W = MAG_W + DPC_W;   // count * dist
  localparam int MS_W = MAG_W + SPS_W;   // count * rate
  localparam int QM_W = MS_W + DPC_W;    // count * rate * dist
  localparam int D_W  = PM_W - 6;        // signed rounded distance
  localparam int W_W  = QM_W - 6;        // signed rounded velocity

  // Merge datapath widths
  localparam int DS_W   = D_W + 2;
  localparam int SUM_W  = W_W + 2;
  localparam int RS_W   = SUM_W + 1;
  localparam int DVM_W  = SUM_W - 1;
  localparam int YAW_FR = 16;
  localparam int HI_W   = DVM_W - YAW_FR;
  localparam int HP_W   = HI_W + ITH_W;
  localparam int LP_W   = YAW_FR + ITH_W;
  localparam int YAW_RND = 32768;
  localparam logic [VEL_W-1:0] YAW_LIM = {1'b1, {(VEL_W-1){1'b0}}};

  // Sequencing
  localparam int STEP_W    = 3;
  localparam int LAT_STEPS = 6;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LAT_STEPS - 1);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_DIST = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SPS  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_ITH  = 2'd2;

  localparam logic [SPS_W-1:0] SPS_RESET = 16'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic signed [D_W-1:0] d;
    logic signed [W_W-1:0] w;
  } lane_out_t;

  typedef struct packed {
    logic commit;
    logic clear;
  } ctl_t;

  typedef struct packed {
    logic [WHEEL_COUNT-1:0][VEL_W-1:0] vel;
    logic [WHEEL_COUNT-1:0][ACC_W-1:0] trip;
    logic [VEL_W-1:0] body_velocity;
    logic [VEL_W-1:0] body_yaw_rate;
    logic [ACC_W-1:0] body_odometer;
    logic [ACC_W-1:0] body_trip;
  } res_t;

  // Round to nearest, ties away from zero, by a right shift of s
  function automatic logic signed [RS_W-1:0] round_shift(input logic signed [RS_W-1:0] x,
                                                         input int unsigned s);
    logic [RS_W-1:0] m;
    logic [RS_W-1:0] r;
    m = x[RS_W-1] ? RS_W'(-x) : RS_W'(x);
    r = (m + (RS_W'(1) << (s - 1))) >> s;
    return x[RS_W-1] ? -signed'(r) : signed'(r);
  endfunction

  // Saturate to a signed 32-bit value
  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [RS_W-1:0] x);
    logic [VEL_W-1:0] r;
    if (x[RS_W-1:VEL_W-1] == '0 || x[RS_W-1:VEL_W-1] == '1) begin
      r = x[VEL_W-1:0];
    end else if (x[RS_W-1]) begin
      r = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- rtl/four_wheel_encoder_odometry_top.sv -----
// Four-wheel encoder odometry.
// Input channel (in_valid/in_stall): one item per encoder sample; action high
// clears the wheel and body trips instead of processing the counts.
// Output channel (out_valid/out_stall): one result item per input item with
// wheel velocities and trips, body velocity, yaw rate, odometer and trip.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 distance per
// count, 1 samples per second, 2 inverse half track; write only while idle.
// One item is in flight at a time. It passes three stages in each of the
// four wheel lanes and three merge stages, then loads the output register,
// and the next item can be accepted in the cycle after the result is loaded.
// A result waiting under out_stall holds its register; a finished item behind
// it waits in the merge stage and in_stall stays high until it moves out.
// Reset zeroes all trips and the odometer, sets samples per second to 100 and
// the two scale registers to zero, and empties the output.
module four_wheel_encoder_odometry_top import odo_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic [CNT_W-1:0]        count_left_front,
  input  logic [CNT_W-1:0]        count_left_back,
  input  logic [CNT_W-1:0]        count_right_front,
  input  logic [CNT_W-1:0]        count_right_back,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VEL_W-1:0] vel_left_front,
  output logic signed [VEL_W-1:0] vel_left_back,
  output logic signed [VEL_W-1:0] vel_right_front,
  output logic signed [VEL_W-1:0] vel_right_back,
  output logic signed [ACC_W-1:0] trip_left_front,
  output logic signed [ACC_W-1:0] trip_left_back,
  output logic signed [ACC_W-1:0] trip_right_front,
  output logic signed [ACC_W-1:0] trip_right_back,
  output logic signed [VEL_W-1:0] body_velocity,
  output logic signed [VEL_W-1:0] body_yaw_rate,
  output logic signed [ACC_W-1:0] body_odometer,
  output logic signed [ACC_W-1:0] body_trip,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  state_t state;
  state_t state_next;
  logic [STEP_W-1:0] step;

  logic [DPC_W-1:0] dist_per_count;
  logic [SPS_W-1:0] samples_per_second;
  logic [ITH_W-1:0] inv_track_half;

  logic                              clear;
  logic [WHEEL_COUNT-1:0][CNT_W-1:0] counts;
  lane_out_t [WHEEL_COUNT-1:0]       lane_res;
  ctl_t                              ctl;
  res_t                              merge_res;
  res_t                              res_q;
  logic                              accept;
  logic                              commit;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_count     <= '0;
      samples_per_second <= SPS_RESET;
      inv_track_half     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIST: dist_per_count     <= cfg_data[DPC_W-1:0];
        CFG_SPS:  samples_per_second <= cfg_data[SPS_W-1:0];
        CFG_ITH:  inv_track_half     <= cfg_data[ITH_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_CALC;
      ST_CALC: if (step == STEP_LAST) state_next = ST_HOLD;
      ST_HOLD: if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    commit   = (state == ST_HOLD) && (!out_valid || !out_stall);
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= (state == ST_CALC) ? step + STEP_W'(1) : '0;
    end
  end

  // Input item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      clear      <= action;
      counts[LF] <= count_left_front;
      counts[LB] <= count_left_back;
      counts[RF] <= count_right_front;
      counts[RB] <= count_right_back;
    end
  end

  // Wheel lanes
  for (genvar g = 0; g < WHEEL_COUNT; g++) begin : g_lane
    odo_lane u_lane (
      .clk                (clk),
      .count              (counts[g]),
      .dist_per_count     (dist_per_count),
      .samples_per_second (samples_per_second),
      .res                (lane_res[g])
    );
  end

  assign ctl.commit = commit;
  assign ctl.clear  = clear;

  odo_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .inv_track_half (inv_track_half),
    .lane           (lane_res),
    .res            (merge_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_q <= merge_res;
    end
  end

  assign vel_left_front   = res_q.vel[LF];
  assign vel_left_back    = res_q.vel[LB];
  assign vel_right_front  = res_q.vel[RF];
  assign vel_right_back   = res_q.vel[RB];
  assign trip_left_front  = res_q.trip[LF];
  assign trip_left_back   = res_q.trip[LB];
  assign trip_right_front = res_q.trip[RF];
  assign trip_right_back  = res_q.trip[RB];
  assign body_velocity    = res_q.body_velocity;
  assign body_yaw_rate    = res_q.body_yaw_rate;
  assign body_odometer    = res_q.body_odometer;
  assign body_trip        = res_q.body_trip;

endmodule

// ----- rtl/odo_lane.sv -----
module odo_lane import odo_pkg::*; (
  input  logic             clk,
  input  logic [CNT_W-1:0] count,
  input  logic [DPC_W-1:0] dist_per_count,
  input  logic [SPS_W-1:0] samples_per_second,
  output lane_out_t        res
);

  logic             n_neg;
  logic [MAG_W-1:0] n_mag;
  logic [CNT_W-1:0] diff;

  logic             a_neg;
  logic [PM_W-1:0]  a_pm;
  logic [MS_W-1:0]  a_ms;

  logic [PM_W:0]    pm_rnd;
  logic [D_W-2:0]   d_mag;
  logic             b_neg;
  logic signed [D_W-1:0] b_d;
  logic [QM_W-1:0]  b_qm;

  logic [QM_W:0]    qm_rnd;
  logic [W_W-2:0]   w_mag;

  // Unwrap the raw counter into sign and magnitude
  always_comb begin
    diff  = '0;
    n_neg = 1'b0;
    n_mag = count[MAG_W-1:0];
    if (count > HALF_C) begin
      if (count < MOD_C) begin
        n_neg = 1'b1;
        diff  = MOD_C - count;
      end else begin
        diff  = count - MOD_C;
      end
      n_mag = diff[MAG_W-1:0];
    end
  end

  // Stage A: count times distance, count times rate
  always_ff @(posedge clk) begin
    a_neg <= n_neg;
    a_pm  <= PM_W'(n_mag) * PM_W'(dist_per_count);
    a_ms  <= MS_W'(n_mag) * MS_W'(samples_per_second);
  end

  assign pm_rnd = {1'b0, a_pm} + (PM_W+1)'(RND_HALF);
  assign d_mag  = pm_rnd[PM_W:RND_SHIFT];

  // Stage B: rounded distance, velocity product
  always_ff @(posedge clk) begin
    b_neg <= a_neg;
    b_d   <= a_neg ? -signed'({1'b0, d_mag}) : signed'({1'b0, d_mag});
    b_qm  <= QM_W'(a_ms) * QM_W'(dist_per_count);
  end

  assign qm_rnd = {1'b0, b_qm} + (QM_W+1)'(RND_HALF);
  assign w_mag  = qm_rnd[QM_W:RND_SHIFT];

  // Stage C: rounded velocity
  always_ff @(posedge clk) begin
    res.d <= b_d;
    res.w <= b_neg ? -signed'({1'b0, w_mag}) : signed'({1'b0, w_mag});
  end

endmodule

// ----- rtl/odo_merge.sv -----
module odo_merge import odo_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  ctl_t                         ctl,
  input  logic [ITH_W-1:0]             inv_track_half,
  input  lane_out_t [WHEEL_COUNT-1:0]  lane,
  output res_t                         res
);

  logic signed [DS_W-1:0]  dsum_c;
  logic signed [SUM_W-1:0] wsum_c;
  logic signed [SUM_W-1:0] wdif_c;

  logic signed [DS_W-1:0]  dsum;
  logic signed [SUM_W-1:0] wsum;
  logic signed [SUM_W-1:0] wdif;

  logic signed [DS_W-1:0]  inc;
  logic signed [SUM_W-1:0] bvel;
  logic signed [SUM_W-1:0] dv;

  logic [DVM_W-1:0] dv_mag;
  logic             y_neg;
  logic [HP_W-1:0]  hi_p;
  logic [LP_W-1:0]  lo_p;

  logic [LP_W:0]    lo_rnd;
  logic [HP_W:0]    r;
  logic [VEL_W-1:0] r_cl;
  logic signed [VEL_W:0] yaw_s;

  logic [WHEEL_COUNT-1:0][ACC_W-1:0] trip;
  logic [WHEEL_COUNT-1:0][ACC_W-1:0] trip_next;
  logic [ACC_W-1:0] odometer;
  logic [ACC_W-1:0] odometer_next;
  logic [ACC_W-1:0] body_trip;
  logic [ACC_W-1:0] body_trip_next;

  // Lane sums
  always_comb begin
    dsum_c = '0;
    wsum_c = '0;
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      dsum_c = dsum_c + DS_W'(lane[i].d);
      wsum_c = wsum_c + SUM_W'(lane[i].w);
    end
    wdif_c = SUM_W'(lane[RF].w) + SUM_W'(lane[RB].w)
           - SUM_W'(lane[LF].w) - SUM_W'(lane[LB].w);
  end

  // M1: sums
  always_ff @(posedge clk) begin
    dsum <= dsum_c;
    wsum <= wsum_c;
    wdif <= wdif_c;
  end

  // M2: rounded body increment, body velocity, velocity difference
  always_ff @(posedge clk) begin
    inc  <= DS_W'(round_shift(RS_W'(dsum), 2));
    bvel <= SUM_W'(round_shift(RS_W'(wsum), 2));
    dv   <= SUM_W'(round_shift(RS_W'(wdif), 1));
  end

  assign dv_mag = dv[SUM_W-1] ? DVM_W'(-dv) : DVM_W'(dv);

  // M3: split yaw product
  always_ff @(posedge clk) begin
    y_neg <= dv[SUM_W-1];
    hi_p  <= HP_W'(dv_mag[DVM_W-1:YAW_FR]) * HP_W'(inv_track_half);
    lo_p  <= LP_W'(dv_mag[YAW_FR-1:0]) * LP_W'(inv_track_half);
  end

  // Yaw combine, clamp, sign
  always_comb begin
    lo_rnd = {1'b0, lo_p} + (LP_W+1)'(YAW_RND);
    r      = {1'b0, hi_p} + (HP_W+1)'(lo_rnd[LP_W:YAW_FR]);
    r_cl   = (r > (HP_W+1)'(YAW_LIM)) ? YAW_LIM : r[VEL_W-1:0];
    yaw_s  = y_neg ? -signed'({1'b0, r_cl}) : signed'({1'b0, r_cl});
  end

  // Accumulator updates
  always_comb begin
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      trip_next[i] = trip[i] + ACC_W'(lane[i].d);
    end
    odometer_next  = odometer + ACC_W'(inc);
    body_trip_next = body_trip + ACC_W'(inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trip      <= '0;
      odometer  <= '0;
      body_trip <= '0;
    end else if (ctl.commit) begin
      if (ctl.clear) begin
        trip      <= '0;
        body_trip <= '0;
      end else begin
        trip      <= trip_next;
        odometer  <= odometer_next;
        body_trip <= body_trip_next;
      end
    end
  end

  // Result item
  always_comb begin
    res = '0;
    if (ctl.clear) begin
      res.body_odometer = odometer;
    end else begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        res.vel[i]  = sat_vel(RS_W'(lane[i].w));
        res.trip[i] = trip_next[i];
      end
      res.body_velocity = sat_vel(RS_W'(bvel));
      res.body_yaw_rate = sat_vel(RS_W'(yaw_s));
      res.body_odometer = odometer_next;
      res.body_trip     = body_trip_next;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  import odo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int END_WAIT_LIMIT = 4000;
  localparam int IDLE_PCT = 12;
  localparam int MAX_PRINTED = 100;
  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic [WHEEL_COUNT-1:0][CNT_W-1:0] counts_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    action = 1'b0;
  logic [CNT_W-1:0]        count_left_front = '0;
  logic [CNT_W-1:0]        count_left_back = '0;
  logic [CNT_W-1:0]        count_right_front = '0;
  logic [CNT_W-1:0]        count_right_back = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VEL_W-1:0] vel_left_front;
  logic signed [VEL_W-1:0] vel_left_back;
  logic signed [VEL_W-1:0] vel_right_front;
  logic signed [VEL_W-1:0] vel_right_back;
  logic signed [ACC_W-1:0] trip_left_front;
  logic signed [ACC_W-1:0] trip_left_back;
  logic signed [ACC_W-1:0] trip_right_front;
  logic signed [ACC_W-1:0] trip_right_back;
  logic signed [VEL_W-1:0] body_velocity;
  logic signed [VEL_W-1:0] body_yaw_rate;
  logic signed [ACC_W-1:0] body_odometer;
  logic signed [ACC_W-1:0] body_trip;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  // Shadow copy of the registers and accumulators
  longint             dist_scale = 0;
  longint             sample_rate = longint'(SPS_RESET);
  longint             inv_track = 0;
  logic [ACC_W-1:0]   wheel_trip_acc [WHEEL_COUNT] = '{default: '0};
  logic [ACC_W-1:0]   odometer_acc = '0;
  logic [ACC_W-1:0]   body_trip_acc = '0;

  res_t expected_results [$];
  int   mismatch_count = 0;
  int   result_count = 0;
  int   cycle_count = 0;
  logic calm = 1'b0;   // no idling on either side while set

  always #2 clk = ~clk;

  four_wheel_encoder_odometry_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .count_left_front  (count_left_front),
    .count_left_back   (count_left_back),
    .count_right_front (count_right_front),
    .count_right_back  (count_right_back),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .vel_left_front    (vel_left_front),
    .vel_left_back     (vel_left_back),
    .vel_right_front   (vel_right_front),
    .vel_right_back    (vel_right_back),
    .trip_left_front   (trip_left_front),
    .trip_left_back    (trip_left_back),
    .trip_right_front  (trip_right_front),
    .trip_right_back   (trip_right_back),
    .body_velocity     (body_velocity),
    .body_yaw_rate     (body_yaw_rate),
    .body_odometer     (body_odometer),
    .body_trip         (body_trip),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // x / 2^s, rounded to nearest with ties away from zero
  function automatic longint round_half_away(input longint x, input int s);
    longint unsigned m;
    longint unsigned r;
    m = (x < 0) ? -x : x;
    r = (m + (64'd1 << (s - 1))) >> s;
    return (x < 0) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [VEL_W-1:0] clamp_vel(input longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[VEL_W-1:0];
  endfunction

  // Velocity difference times inverse half track, Q16 product rounded
  function automatic longint yaw_from_diff(input longint dv);
    longint unsigned m;
    longint unsigned r;
    m = (dv < 0) ? -dv : dv;
    r = (m >> 16) * inv_track + (((m & 64'hFFFF) * inv_track + 64'h8000) >> 16);
    if (r > 64'h8000_0000) r = 64'h8000_0000;
    return (dv < 0) ? -$signed(r) : $signed(r);
  endfunction

  // Advance the shadow state by one sample and return the expected result
  function automatic res_t predict_odometry(input logic clr, input counts_t cnt);
    res_t   res;
    longint n;
    longint p;
    longint dsum;
    longint inc;
    longint d [WHEEL_COUNT];
    longint w [WHEEL_COUNT];
    res = '0;
    if (clr) begin
      foreach (wheel_trip_acc[i]) wheel_trip_acc[i] = '0;
      body_trip_acc = '0;
      res.body_odometer = odometer_acc;
      return res;
    end
    dsum = 0;
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      n = longint'(cnt[i]);
      if (n > COUNTER_MODULUS / 2) n -= COUNTER_MODULUS;
      p = n * dist_scale;
      d[i] = round_half_away(p, RND_SHIFT);
      w[i] = round_half_away(p * sample_rate, RND_SHIFT);
      wheel_trip_acc[i] = wheel_trip_acc[i] + ACC_W'(d[i]);
      dsum += d[i];
      res.vel[i] = clamp_vel(w[i]);
      res.trip[i] = wheel_trip_acc[i];
    end
    inc = round_half_away(dsum, 2);
    odometer_acc = odometer_acc + ACC_W'(inc);
    body_trip_acc = body_trip_acc + ACC_W'(inc);
    res.body_velocity = clamp_vel(round_half_away(w[LF] + w[LB] + w[RF] + w[RB], 2));
    res.body_yaw_rate = clamp_vel(yaw_from_diff(
        round_half_away(w[RF] + w[RB] - w[LF] - w[LB], 1)));
    res.body_odometer = odometer_acc;
    res.body_trip = body_trip_acc;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("[%0t] ERROR %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [ACC_W-1:0] got,
                             input logic [ACC_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h want %h",
                                result_count, name, got, want));
  endtask

  // Send one sample item, with a random gap ahead of it unless calm
  task automatic send_sample(input logic clr, input counts_t cnt);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    action            <= clr;
    count_left_front  <= cnt[LF];
    count_left_back   <= cnt[LB];
    count_right_front <= cnt[RF];
    count_right_back  <= cnt[RB];
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_odometry(clr, cnt));
  endtask

  task automatic send_counts(input int lf, input int lb, input int rf, input int rb);
    counts_t cnt;
    cnt[LF] = CNT_W'(lf);
    cnt[LB] = CNT_W'(lb);
    cnt[RF] = CNT_W'(rf);
    cnt[RB] = CNT_W'(rb);
    send_sample(1'b0, cnt);
  endtask

  // Let every result drain so the block sits idle
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIST: dist_scale = longint'(val);
      CFG_SPS:  sample_rate = longint'(val[SPS_W-1:0]);
      CFG_ITH:  inv_track = longint'(val);
      default:  ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Boundary-heavy mix over the full 14-bit field
  function automatic logic [CNT_W-1:0] random_count();
    case ($urandom_range(0, 9))
      0, 1, 2: return CNT_W'($urandom_range(0, 300));
      3, 4:    return CNT_W'(COUNTER_MODULUS - $urandom_range(1, 300));
      5: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return HALF_C;
          2:       return HALF_C + 1'b1;
          3:       return MOD_C - 1'b1;
          4:       return MOD_C;
          default: return '1;
        endcase
      end
      default: return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_setting(input int width);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_W'((64'd1 << width) - 1);
      2:       return CFG_W'(1);
      3:       return CFG_W'($urandom_range(0, 65535));
      default: return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    endcase
  endfunction

  // Mostly vehicle-like motion: common speed, side turn, small per-wheel slip
  task automatic send_random_samples(input int n_items);
    counts_t cnt;
    int      speed;
    int      turn;
    int      v;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < 5) begin
        cnt = {WHEEL_COUNT{random_count()}};
        send_sample(1'b1, cnt);
      end else if ($urandom_range(99) < 55) begin
        speed = int'($urandom_range(0, 1600)) - 800;
        turn = int'($urandom_range(0, 400)) - 200;
        for (int i = 0; i < WHEEL_COUNT; i++) begin
          v = speed + ((i == RF || i == RB) ? turn : -turn) + int'($urandom_range(0, 20)) - 10;
          cnt[i] = CNT_W'((v + COUNTER_MODULUS) % COUNTER_MODULUS);
        end
        send_sample(1'b0, cnt);
      end else begin
        for (int i = 0; i < WHEEL_COUNT; i++) cnt[i] = random_count();
        send_sample(1'b0, cnt);
      end
    end
  endtask

  // Reset settings: zero scale first, then the default sample rate shows
  task automatic test_reset_values();
    counts_t cnt;
    send_counts(HALF_C, HALF_C + 1, MOD_C - 1, (1 << CNT_W) - 1);
    send_counts(0, 1, 2, 3);
    cnt = '1;
    send_sample(1'b1, cnt);
    wait_for_idle();
    write_register(CFG_DIST, 24'h01_0000);
    send_counts(100, 200, 9900, 9800);
    send_counts(HALF_C, HALF_C, HALF_C, HALF_C);
    send_counts(MOD_C, MOD_C - 1, 0, 1);
  endtask

  // Largest scales: saturation, count unwrap edges, counts above the modulus
  task automatic test_extremes();
    counts_t cnt;
    wait_for_idle();
    write_register(CFG_DIST, '1);
    write_register(CFG_SPS, CFG_W'(16'hFFFF));
    write_register(CFG_ITH, '1);
    send_counts(HALF_C, HALF_C, HALF_C, HALF_C);
    send_counts(HALF_C + 1, HALF_C + 1, HALF_C + 1, HALF_C + 1);
    send_counts(HALF_C + 1, HALF_C + 1, HALF_C, HALF_C);
    send_counts(HALF_C, HALF_C, HALF_C + 1, HALF_C + 1);
    send_counts((1 << CNT_W) - 1, (1 << CNT_W) - 1, (1 << CNT_W) - 1, (1 << CNT_W) - 1);
    send_counts(MOD_C, MOD_C, MOD_C, MOD_C);
    send_counts(MOD_C - 1, MOD_C - 1, MOD_C - 1, MOD_C - 1);
    send_counts(0, 0, 0, 0);
    send_counts(1, HALF_C - 1, MOD_C + 1, 8192);
    cnt = '0;
    send_sample(1'b1, cnt);
  endtask

  // Zero sample rate, minimum sample rate, zero inverse track, unused index
  task automatic test_zero_rate();
    wait_for_idle();
    write_register(CFG_SPS, '0);
    write_register(CFG_UNUSED, CFG_W'($urandom));
    send_counts(HALF_C, HALF_C + 1, 0, (1 << CNT_W) - 1);
    send_counts(3, 2, 9998, 9997);
    wait_for_idle();
    write_register(CFG_SPS, 24'hFF_0001);   // upper bits beyond the field
    write_register(CFG_ITH, '0);
    send_counts(HALF_C, HALF_C, HALF_C + 1, HALF_C + 1);
    send_counts(10, 20, 30, 40);
  endtask

  // Several register settings, one phase without idling on either side
  task automatic test_random_settings();
    for (int phase = 0; phase < 9; phase++) begin
      wait_for_idle();
      if (phase == 0) begin
        write_register(CFG_DIST, '1);
        write_register(CFG_SPS, CFG_W'(16'hFFFF));
        write_register(CFG_ITH, '1);
      end else if (phase == 1) begin
        write_register(CFG_DIST, CFG_W'(1));
        write_register(CFG_SPS, CFG_W'(1));
        write_register(CFG_ITH, CFG_W'(1));
      end else begin
        write_register(CFG_DIST, random_setting(DPC_W));
        write_register(CFG_SPS, random_setting(SPS_W) | CFG_W'(phase[0]));
        write_register(CFG_ITH, random_setting(ITH_W));
        if (phase == 2) write_register(CFG_UNUSED, CFG_W'($urandom));
      end
      calm = (phase == 4);
      send_random_samples(190);
      calm = 1'b0;
    end
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      got.vel[LF] = vel_left_front;
      got.vel[LB] = vel_left_back;
      got.vel[RF] = vel_right_front;
      got.vel[RB] = vel_right_back;
      got.trip[LF] = trip_left_front;
      got.trip[LB] = trip_left_back;
      got.trip[RF] = trip_right_front;
      got.trip[RB] = trip_right_back;
      got.body_velocity = body_velocity;
      got.body_yaw_rate = body_yaw_rate;
      got.body_odometer = body_odometer;
      got.body_trip = body_trip;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", result_count));
      end else begin
        want = expected_results.pop_front();
        for (int i = 0; i < WHEEL_COUNT; i++) begin
          check_field($sformatf("vel[%0d]", i), got.vel[i], want.vel[i]);
          check_field($sformatf("trip[%0d]", i), got.trip[i], want.trip[i]);
        end
        check_field("body_velocity", got.body_velocity, want.body_velocity);
        check_field("body_yaw_rate", got.body_yaw_rate, want.body_yaw_rate);
        check_field("body_odometer", got.body_odometer, want.body_odometer);
        check_field("body_trip", got.body_trip, want.body_trip);
      end
      result_count++;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("four_wheel_encoder_odometry_top: mismatch");
      $finish;
    end
  end

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_zero_rate();
    test_random_settings();

    // Drain, then flag anything still outstanding
    in_valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatch_count == 0) begin
      $display("four_wheel_encoder_odometry_top: match");
    end else begin
      $display("four_wheel_encoder_odometry_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/odo_pkg.sv
rtl/odo_lane.sv
rtl/odo_merge.sv
rtl/four_wheel_encoder_odometry_top.sv
dv/tb_top.sv
